[rtl/rna_pkg.sv]
// Package with shared types, codes and constants of the rational number ALU.
package rna_pkg;

  localparam int unsigned VALUE_WIDTH_DEF = 32;
  localparam int unsigned NUM_W  = 32;
  localparam int unsigned DEN_W  = 31;
  localparam int unsigned WIDE_W = 64;

  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_MUL = 3'd2;
  localparam logic [2:0] OP_DIV = 3'd3;
  localparam logic [2:0] OP_NEG = 3'd4;
  localparam logic [2:0] OP_CMP = 3'd5;
  localparam logic [2:0] OP_INC = 3'd6;

  localparam logic [1:0] ORD_LT = 2'd0;
  localparam logic [1:0] ORD_EQ = 2'd1;
  localparam logic [1:0] ORD_GT = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZERO = 2'd1;
  localparam logic [1:0] ST_OVF  = 2'd2;

  // One classified operation handed from the front end to the reducer.
  typedef struct packed {
    logic              run;
    logic              neg;
    logic [WIDE_W-1:0] mag;
    logic [WIDE_W-1:0] den;
    logic [1:0]        order;
    logic [1:0]        status;
  } job_t;

endpackage

[rtl/rna_front.sv]
// Front end: forms the cross products in states S_MUL1 and S_MUL2 and classifies the operation.
module rna_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [2:0]          in_req_type,
  input  logic signed [31:0]  in_a_num,
  input  logic [30:0]         in_a_den,
  input  logic signed [31:0]  in_b_num,
  input  logic [30:0]         in_b_den,
  input  logic                q_full,
  output logic                job_valid,
  output rna_pkg::job_t       job
);
  import rna_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL1 = 2'd1;
  localparam logic [1:0] S_MUL2 = 2'd2;
  localparam logic [1:0] S_PUSH = 2'd3;

  logic [1:0]         state_r, state_nxt;
  logic [2:0]         op_r;
  logic signed [31:0] an_r, bn_r;
  logic [30:0]        ad_r, bd_r;
  logic signed [63:0] l_r, r_r, p_r;
  logic [63:0]        dd_r;
  logic signed [63:0] mul_a, mul_b, mul_p;
  logic [63:0]        mul_u;

  // One signed cross product and one further 32-bit product per cycle; the further product is unsigned only in S_MUL1.
  always_comb begin
    mul_a = 64'(an_r);
    mul_b = 64'(bd_r);
    mul_u = 64'(ad_r) * 64'(bd_r);
    if (state_r == S_MUL2) begin
      mul_a = 64'(bn_r);
      mul_b = 64'(ad_r);
      mul_u = 64'(an_r) * 64'(bn_r);
      // Divide needs ad*bn as its denominator instead of the numerator product.
      if (op_r == OP_DIV) mul_u = 64'(signed'({1'b0, ad_r})) * 64'(bn_r);
    end
    mul_p = 64'(signed'(mul_a[31:0])) * 64'(mul_b[31:0]);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (start) state_nxt = S_MUL1;
      S_MUL1: state_nxt = S_MUL2;
      S_MUL2: state_nxt = S_PUSH;
      S_PUSH: if (!q_full) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && start) begin
      op_r <= in_req_type;
      an_r <= in_a_num; ad_r <= in_a_den;
      bn_r <= in_b_num; bd_r <= in_b_den;
    end
    if (state_r == S_MUL1) begin
      l_r  <= mul_p;
      dd_r <= mul_u;
    end
    if (state_r == S_MUL2) begin
      r_r <= mul_p;
      p_r <= signed'(mul_u);
    end
  end

  assign busy = (state_r != S_IDLE);

  logic signed [63:0] n, d;
  logic               uses_b;
  always_comb begin
    uses_b     = (op_r <= OP_DIV) || (op_r == OP_CMP);
    n          = '0;
    d          = 64'sd1;
    job        = '0;
    job.order  = (l_r < r_r) ? ORD_LT : ((l_r == r_r) ? ORD_EQ : ORD_GT);
    job.status = ST_OK;
    if (op_r <= OP_INC && (ad_r == '0 || (uses_b && bd_r == '0))) begin
      job.status = ST_ZERO;
    end else begin
      unique case (op_r)
        OP_ADD: begin n = l_r + r_r; d = signed'(dd_r); job.run = 1'b1; end
        OP_SUB: begin n = l_r - r_r; d = signed'(dd_r); job.run = 1'b1; end
        OP_MUL: begin n = p_r;       d = signed'(dd_r); job.run = 1'b1; end
        OP_DIV: begin
          if (bn_r == '0) job.status = ST_ZERO;
          else begin
            n = l_r;
            d = p_r;
            job.run = 1'b1;
          end
        end
        OP_NEG: begin n = -64'(an_r); d = 64'(ad_r); job.run = 1'b1; end
        OP_INC: begin n = 64'(an_r) + 64'(ad_r); d = 64'(ad_r); job.run = 1'b1; end
        default: job.run = 1'b0;
      endcase
    end
    job.neg = (n < 0) != (d < 0);
    job.den = (d < 0) ? 64'(-d) : 64'(d);
    job.mag = (n < 0) ? 64'(-n) : 64'(n);
  end

  assign job_valid = (state_r == S_PUSH) && !q_full;
endmodule

[rtl/rna_queue.sv]
// Two-entry queue between the front end and the reducer.
module rna_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  rna_pkg::job_t wdata,
  output logic          full,
  input  logic          pop,
  output logic          not_empty,
  output rna_pkg::job_t rdata
);
  import rna_pkg::*;

  job_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wdata;
  end

  assign rdata     = mem_r[rp_r];
  assign full      = (cnt_r == 2'd2);
  assign not_empty = (cnt_r != 2'd0);
endmodule

[rtl/rna_reduce.sv]
// Back end: binary GCD reduction, exact division by the GCD and range check.
module rna_reduce #(
  parameter int unsigned VALUE_WIDTH = rna_pkg::VALUE_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                job_valid,
  input  rna_pkg::job_t       job,
  output logic                job_pop,
  output logic                out_valid,
  output logic signed [31:0]  out_res_num,
  output logic [30:0]         out_res_den,
  output logic [1:0]          out_order,
  output logic [1:0]          out_status
);
  import rna_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_GCD  = 3'd1;
  localparam logic [2:0] S_DIVN = 3'd2;
  localparam logic [2:0] S_DIVD = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;
  localparam logic [63:0] MAXPOS = (64'd1 << (VALUE_WIDTH - 1)) - 64'd1;

  logic [2:0]  state_r, state_nxt;
  job_t        job_r;
  logic [63:0] u_r, v_r;
  logic [6:0]  k_r;
  logic [63:0] rem_r, quo_r, dvd_r, g_r, qn_r;
  logic [6:0]  bit_r;
  logic [64:0] trial;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (job_valid) state_nxt = S_GCD;
      S_GCD:  if (!job_r.run || job_r.mag == '0 || u_r == '0) state_nxt = S_DIVN;
      S_DIVN: if (!job_r.run || job_r.mag == '0 || bit_r == 7'd0) state_nxt = S_DIVD;
      S_DIVD: if (!job_r.run || job_r.mag == '0 || bit_r == 7'd0) state_nxt = S_DONE;
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  assign trial = {rem_r, dvd_r[63]} - {1'b0, g_r};

  // Binary GCD on (mag, den); then two restoring divides by the GCD.
  // The odd/odd step leaves u at zero once both values match; v then holds the odd part.
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: if (job_valid) begin
        job_r <= job;
        u_r   <= job.mag;
        v_r   <= job.den;
        k_r   <= '0;
      end
      S_GCD: begin
        if (u_r == '0) begin
          g_r   <= v_r << k_r;
          rem_r <= '0; dvd_r <= job_r.mag; bit_r <= 7'd63;
        end else if (!u_r[0] && !v_r[0]) begin
          u_r <= u_r >> 1; v_r <= v_r >> 1; k_r <= k_r + 7'd1;
        end else if (!u_r[0]) u_r <= u_r >> 1;
        else if (!v_r[0]) v_r <= v_r >> 1;
        else if (u_r >= v_r) u_r <= (u_r - v_r) >> 1;
        else begin
          v_r <= (v_r - u_r) >> 1;
        end
      end
      S_DIVN, S_DIVD: begin
        quo_r <= {quo_r[62:0], ~trial[64]};
        if (state_r == S_DIVN && bit_r == 7'd0) begin
          qn_r  <= {quo_r[62:0], ~trial[64]};
          rem_r <= '0; dvd_r <= job_r.den; bit_r <= 7'd63;
        end else begin
          rem_r <= trial[64] ? {rem_r[62:0], dvd_r[63]} : trial[63:0];
          dvd_r <= dvd_r << 1;
          if (bit_r != 7'd0) bit_r <= bit_r - 7'd1;
        end
      end
      default: ;
    endcase
  end

  logic [63:0] dq;
  assign dq = quo_r;

  always_comb begin
    out_valid   = (state_r == S_DONE);
    out_order   = job_r.order;
    out_status  = job_r.status;
    out_res_num = '0;
    out_res_den = '0;
    if (job_r.status == ST_OK && job_r.run) begin
      if (job_r.mag == '0) begin
        out_res_den = 31'd1;
      end else if (dq > MAXPOS ||
                   (job_r.neg ? (qn_r > MAXPOS + 64'd1) : (qn_r > MAXPOS))) begin
        out_status = ST_OVF;
      end else begin
        out_res_den = dq[30:0];
        out_res_num = job_r.neg ? 32'(-qn_r) : qn_r[31:0];
      end
    end
  end

  assign job_pop = (state_r == S_IDLE) && job_valid;
endmodule

[rtl/rational_number_alu_top.sv]
// Top level of the rational number ALU: front end, queue and GCD reducer.
// Usage: raise start with in_req_type and the two fractions on the in_ ports;
// the transaction is taken at a rising edge where start is high and busy low.
// After that edge busy stays high in S_MUL1, S_MUL2 and S_PUSH while the
// front end forms the 64-bit cross products, classifies the transaction and
// pushes it into a two-entry queue; busy stays high longer only while that
// queue is full. The back end runs a binary GCD (each step drops at least
// one bit of the two values, so the steps are bounded by their combined
// width) and two 64-step restoring divides. Compares, errors, zero results
// and the unused selector skip the loops and pass straight through the
// reducer states. The reducer takes a new transaction only when idle, while
// the front end may already take the next one.
// Each result is shown for one cycle with out_valid high; the receiver cannot
// stall, so the result is dropped onto the ports and never held.
// Synchronous active-low reset empties the queue and returns both control
// machines to idle; no transaction is in flight afterwards.
// out_status reports ok, a zero denominator, or overflow of the reduced value
// at VALUE_WIDTH bits; out_order always compares a with b exactly.
module rational_number_alu_top #(
  parameter int unsigned VALUE_WIDTH = rna_pkg::VALUE_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [2:0]          in_req_type,
  input  logic signed [31:0]  in_a_num,
  input  logic [30:0]         in_a_den,
  input  logic signed [31:0]  in_b_num,
  input  logic [30:0]         in_b_den,
  output logic                out_valid,
  output logic signed [31:0]  out_res_num,
  output logic [30:0]         out_res_den,
  output logic [1:0]          out_order,
  output logic [1:0]          out_status
);
  import rna_pkg::*;

  job_t push_job, pop_job;
  logic push, q_full, q_ne, pop;

  rna_front u_front (
    .clk, .rst_n, .start, .busy,
    .in_req_type, .in_a_num, .in_a_den, .in_b_num, .in_b_den,
    .q_full, .job_valid(push), .job(push_job)
  );

  rna_queue u_queue (
    .clk, .rst_n, .push, .wdata(push_job), .full(q_full),
    .pop, .not_empty(q_ne), .rdata(pop_job)
  );

  rna_reduce #(.VALUE_WIDTH(VALUE_WIDTH)) u_reduce (
    .clk, .rst_n, .job_valid(q_ne), .job(pop_job), .job_pop(pop),
    .out_valid, .out_res_num, .out_res_den, .out_order, .out_status
  );

`ifndef NO_ASSERTIONS
  // A failed result never carries a fraction.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_res_num == '0 && out_res_den == '0)
    else $error("nonzero fraction with failing status");
  // The ordering is always one of the three defined codes.
  a_order_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_order != 2'd3)
    else $error("invalid order code");
  // Never push into a full queue.
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_full)
    else $error("queue overrun");
`endif
endmodule
